@@ rtl/htq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htq_pkg
// Shared widths, codes and defaults of the timer expiry queue.
// ----------------------------------------------------------------------------
package htq_pkg;
   localparam int DATA_W = 32;
   localparam int CAPACITY_DEF = 32;
   localparam int CSR_IDX_W = 1;
   localparam logic [DATA_W-1:0] TICK_MAX = '1;
   localparam logic [DATA_W-1:0] PERIOD_RST = 32'd10;

   typedef enum logic [0:0] {
      CMD_CREATE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_EXPIRED = 2'd1,
      KIND_DONE    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TASK_TAG    = 1'b0,
      CSR_TASK_PERIOD = 1'b1
   } csr_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              status;
      logic [DATA_W-1:0] expired_deadline;
      logic signed [DATA_W-1:0] expired_tag;
      logic              task_due;
      logic [DATA_W-1:0] current_tick;
      logic              last;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/htq_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htq_req_if / htq_rsp_if
// Valid/ready channels for requests and results of the timer queue.
// ----------------------------------------------------------------------------
interface htq_req_if;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [31:0]              deadline;
   logic signed [31:0]       tag;
   modport source (output valid, cmd, deadline, tag, input ready);
   modport sink (input valid, cmd, deadline, tag, output ready);
endinterface

interface htq_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic                     status;
   logic [31:0]              expired_deadline;
   logic signed [31:0]       expired_tag;
   logic                     task_due;
   logic [31:0]              current_tick;
   logic                     last;
   modport source (output valid, kind, status, expired_deadline, expired_tag,
                    task_due, current_tick, last, input ready);
   modport sink (input valid, kind, status, expired_deadline, expired_tag,
                  task_due, current_tick, last, output ready);
endinterface
`default_nettype wire

@@ rtl/htq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htq_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/heap_timer_expiry_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heap_timer_expiry_queue
// Binary min-heap of timers with a saturating tick counter.
// ----------------------------------------------------------------------------
// Requests arrive on req (cmd, deadline, tag); results leave on rsp. A create
// request inserts a timer and returns one acknowledge (status 1 when full). A
// tick request bumps the tick, then pops every due timer: the task timer is
// re-armed at tick + task_period, every other one is sent as an expired
// result, and a finished result with last set closes the tick.
// All heap work runs through one sequencer and one 64-bit heap RAM (one read
// and one write a cycle), with comparators on deadlines. A create climbs the
// heap level by level; each popped timer sifts down level by level, and the
// re-armed task timer is then inserted again by the same climb.
// One request is worked at a time; req.ready is low until its last result is
// taken. Each result waits in the output register while rsp.ready is low;
// the sequencer holds before the next result meanwhile. Reset empties the
// heap, clears the tick and loads task_tag 0, task_period 10; no clearing
// pass is needed. csr writes are taken at any time and are meant for idle
// periods.
// ----------------------------------------------------------------------------
module heap_timer_expiry_queue #(
   parameter int CAPACITY = htq_pkg::CAPACITY_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   htq_req_if.sink                                     req,
   htq_rsp_if.source                                   rsp,
   input  wire logic                                   csr_wr_en,
   input  wire logic [htq_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [htq_pkg::DATA_W-1:0]             csr_wdata
);
   localparam int AW = $clog2(CAPACITY + 1);
   localparam int DW = htq_pkg::DATA_W;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_UPRD   = 12'b000000000010,
      ST_UPCMP  = 12'b000000000100,
      ST_TOPRD  = 12'b000000001000,
      ST_TOPCHK = 12'b000000010000,
      ST_LASTRD = 12'b000000100000,
      ST_DNL    = 12'b000001000000,
      ST_DNR    = 12'b000010000000,
      ST_DNCMP  = 12'b000100000000,
      ST_EMIT   = 12'b001000000000,
      ST_REARM  = 12'b010000000000,
      ST_OUT    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [DW-1:0] task_tag_ff, task_tag_in, period_ff, period_in;
   logic [AW-1:0] count_ff, count_in, budget_ff, budget_in;
   logic [AW-1:0] pos_ff, pos_in, child_ff, child_in;
   logic [DW-1:0] tick_ff, tick_in;
   logic [DW-1:0] cur_dl_ff, cur_dl_in, cur_tg_ff, cur_tg_in;  // item moving
   logic [DW-1:0] cl_dl_ff, cl_dl_in, cl_tg_ff, cl_tg_in;      // left child
   logic [DW-1:0] top_dl_ff, top_dl_in, top_tg_ff, top_tg_in;
   logic due_ff, due_in, tick_op_ff, tick_op_in, after_ff, after_in;
   htq_pkg::rsp_type out_ff, out_in;
   logic out_vld_ff, out_vld_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [2*DW-1:0] wr_data, rd_data;
   logic [DW-1:0] rd_dl, rd_tg;
   logic [DW:0]   rearm_sum;

   htq_ram #(.WIDTH(2 * DW), .DEPTH(2 ** AW)) u_heap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_dl = rd_data[2*DW-1:DW];
   assign rd_tg = rd_data[DW-1:0];
   assign rearm_sum = {1'b0, tick_ff} + {1'b0, period_ff};

   assign req.ready = (state_ff == ST_IDLE) && !out_vld_ff;
   assign rsp.valid = out_vld_ff;
   assign rsp.kind = out_ff.kind;
   assign rsp.status = out_ff.status;
   assign rsp.expired_deadline = out_ff.expired_deadline;
   assign rsp.expired_tag = out_ff.expired_tag;
   assign rsp.task_due = out_ff.task_due;
   assign rsp.current_tick = out_ff.current_tick;
   assign rsp.last = out_ff.last;

   always_comb begin
      state_in = state_ff;
      task_tag_in = task_tag_ff;
      period_in = period_ff;
      count_in = count_ff;
      budget_in = budget_ff;
      pos_in = pos_ff;
      child_in = child_ff;
      tick_in = tick_ff;
      cur_dl_in = cur_dl_ff;
      cur_tg_in = cur_tg_ff;
      cl_dl_in = cl_dl_ff;
      cl_tg_in = cl_tg_ff;
      top_dl_in = top_dl_ff;
      top_tg_in = top_tg_ff;
      due_in = due_ff;
      tick_op_in = tick_op_ff;
      after_in = after_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = {cur_dl_ff, cur_tg_ff};
      rd_addr = pos_ff >> 1;

      if (out_vld_ff && rsp.ready) begin
         out_vld_in = 1'b0;
      end

      if (csr_wr_en) begin
         case (csr_index)
            htq_pkg::CSR_TASK_TAG:    task_tag_in = csr_wdata;
            htq_pkg::CSR_TASK_PERIOD: period_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               out_in = '0;
               if (req.cmd == htq_pkg::CMD_CREATE) begin
                  tick_op_in = 1'b0;
                  out_in.kind = htq_pkg::KIND_ACK;
                  out_in.current_tick = tick_ff;
                  out_in.last = 1'b1;
                  if (count_ff >= AW'(CAPACITY)) begin
                     out_in.status = 1'b1;
                     out_vld_in = 1'b1;
                  end else begin
                     cur_dl_in = req.deadline;
                     cur_tg_in = req.tag;
                     count_in = count_ff + 1'b1;
                     pos_in = count_ff + 1'b1;
                     state_in = ST_UPRD;
                  end
               end else begin
                  tick_op_in = 1'b1;
                  due_in = 1'b0;
                  if (tick_ff != htq_pkg::TICK_MAX) begin
                     tick_in = tick_ff + 1'b1;
                  end
                  budget_in = count_ff;
                  pos_in = AW'(1);
                  state_in = ST_TOPRD;
               end
            end
         end
         // sift up: read parent of pos
         ST_UPRD: begin
            rd_addr = pos_ff >> 1;
            state_in = ST_UPCMP;
         end
         ST_UPCMP: begin
            if (pos_ff > AW'(1) && cur_dl_ff < rd_dl) begin
               wr_en = 1'b1;
               wr_data = rd_data;
               pos_in = pos_ff >> 1;
               state_in = ST_UPRD;
            end else begin
               wr_en = 1'b1;
               if (tick_op_ff) begin
                  state_in = ST_TOPRD;
                  pos_in = AW'(1);
               end else begin
                  out_vld_in = 1'b1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_TOPRD: begin
            rd_addr = AW'(1);
            state_in = ST_TOPCHK;
         end
         ST_TOPCHK: begin
            // keep the root on the read port while the finished result waits
            rd_addr = AW'(1);
            if (budget_ff != '0 && count_ff != '0 && rd_dl <= tick_ff) begin
               top_dl_in = rd_dl;
               top_tg_in = rd_tg;
               budget_in = budget_ff - 1'b1;
               state_in = ST_LASTRD;
            end else if (!out_vld_ff) begin
               out_in = '0;
               out_in.kind = htq_pkg::KIND_DONE;
               out_in.task_due = due_ff;
               out_in.current_tick = tick_ff;
               out_in.last = 1'b1;
               out_vld_in = 1'b1;
               tick_op_in = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_LASTRD: begin
            // carry the last entry down from the root
            rd_addr = count_ff;
            state_in = ST_DNL;
            pos_in = AW'(1);
            count_in = count_ff - 1'b1;
            after_in = 1'b0;
         end
         ST_DNL: begin
            if (!after_ff) begin
               cur_dl_in = rd_dl;
               cur_tg_in = rd_tg;
            end
            if ({pos_ff, 1'b0} > {1'b0, count_ff}) begin
               wr_en = 1'b1;
               if (!after_ff) wr_data = rd_data;
               state_in = ST_EMIT;
            end else begin
               rd_addr = AW'({pos_ff, 1'b0});
               child_in = AW'({pos_ff, 1'b0});
               state_in = ST_DNR;
            end
         end
         ST_DNR: begin
            cl_dl_in = rd_dl;
            cl_tg_in = rd_tg;
            rd_addr = child_ff + 1'b1;
            if (child_ff + 1'b1 <= count_ff && child_ff != '1) begin
               state_in = ST_DNCMP;
               after_in = 1'b1;
            end else begin
               state_in = ST_DNCMP;
               after_in = 1'b0;
            end
         end
         ST_DNCMP: begin
            // pick the earlier child; right only if strictly earlier
            logic [DW-1:0] c_dl, c_tg;
            logic [AW-1:0] c_idx;
            c_dl = cl_dl_ff;
            c_tg = cl_tg_ff;
            c_idx = child_ff;
            if (after_ff && rd_dl < cl_dl_ff) begin
               c_dl = rd_dl;
               c_tg = rd_tg;
               c_idx = child_ff + 1'b1;
            end
            after_in = 1'b1;
            wr_en = 1'b1;
            if (c_dl < cur_dl_ff) begin
               wr_data = {c_dl, c_tg};
               pos_in = c_idx;
               state_in = ST_DNL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (top_tg_ff == task_tag_ff) begin
               due_in = 1'b1;
               cur_dl_in = rearm_sum[DW] ? htq_pkg::TICK_MAX : rearm_sum[DW-1:0];
               cur_tg_in = task_tag_ff;
               state_in = ST_REARM;
            end else if (!out_vld_ff) begin
               out_in = '0;
               out_in.kind = htq_pkg::KIND_EXPIRED;
               out_in.expired_deadline = top_dl_ff;
               out_in.expired_tag = top_tg_ff;
               out_in.current_tick = tick_ff;
               out_vld_in = 1'b1;
               state_in = ST_TOPRD;
            end
         end
         ST_REARM: begin
            // the pop freed a slot, so the insert always fits
            count_in = count_ff + 1'b1;
            pos_in = count_ff + 1'b1;
            state_in = ST_UPRD;
         end
         ST_OUT: begin
            if (!out_vld_in) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         task_tag_ff <= '0;
         period_ff <= htq_pkg::PERIOD_RST;
         count_ff <= '0;
         tick_ff <= '0;
         out_vld_ff <= 1'b0;
         tick_op_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         task_tag_ff <= task_tag_in;
         period_ff <= period_in;
         count_ff <= count_in;
         tick_ff <= tick_in;
         out_vld_ff <= out_vld_in;
         tick_op_ff <= tick_op_in;
      end
      budget_ff <= budget_in;
      pos_ff <= pos_in;
      child_ff <= child_in;
      cur_dl_ff <= cur_dl_in;
      cur_tg_ff <= cur_tg_in;
      cl_dl_ff <= cl_dl_in;
      cl_tg_ff <= cl_tg_in;
      top_dl_ff <= top_dl_in;
      top_tg_ff <= top_tg_in;
      due_ff <= due_in;
      after_ff <= after_in;
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

@@ rtl/htq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module htq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic        rsp_last,
   input wire logic        rsp_status,
   input wire logic [31:0] rsp_current_tick
);
   a_no_ready_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result waits");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == htq_pkg::KIND_ACK || rsp_kind == htq_pkg::KIND_EXPIRED ||
                     rsp_kind == htq_pkg::KIND_DONE))
      else $error("bad result kind");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != htq_pkg::KIND_EXPIRED)))
      else $error("last flag does not match kind");

   a_status_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_kind == htq_pkg::KIND_ACK)
      else $error("status set outside an acknowledge");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_tick))
      else $error("stalled result changed");
endmodule

bind heap_timer_expiry_queue htq_checker u_htq_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind), .rsp_last(rsp.last), .rsp_status(rsp.status),
   .rsp_current_tick(rsp.current_tick)
);
`default_nettype wire
